/* sv/sli_pkg.sv */
// sorted list insert/delete: shared types, status codes and field layout
// used by the cell, the top level and the port checker; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sli_pkg;

  localparam int unsigned CapacityDef = 64;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 7;
  localparam int unsigned StatusW = 2;

  // opcode of an input transfer
  localparam logic OpInsert = 1'b0;
  localparam logic OpDelete = 1'b1;

  // result status codes
  localparam logic [StatusW-1:0] StInserted = 2'd0;
  localparam logic [StatusW-1:0] StDeleted = 2'd1;
  localparam logic [StatusW-1:0] StNotFound = 2'd2;
  localparam logic [StatusW-1:0] StFull = 2'd3;

  // stream widths, whole bytes
  localparam int unsigned InDataW = 40;
  localparam int unsigned OutDataW = 48;

  // output field positions
  localparam int unsigned OutStatusLsb = 0;
  localparam int unsigned OutCountLsb = 2;
  localparam int unsigned OutSmallLsb = 9;
  localparam int unsigned OutValidBit = 41;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic del_en;
  } cell_cmd_t;

endpackage

`default_nettype wire

/* sv/sli_cell.sv */
// sorted list insert/delete: one storage cell of the sorted chain
// depends on sli_pkg; neighbors exchange entries and position flags
`timescale 1ns / 1ps
`default_nettype none

module sli_cell #(
  parameter int unsigned Idx = 0,
  parameter int unsigned CntW = 7
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire sli_pkg::cell_cmd_t                  cmd_i,
  input  wire logic signed [sli_pkg::ValueW-1:0]   key_i,
  input  wire logic [CntW-1:0]                     count_i,
  input  wire logic signed [sli_pkg::ValueW-1:0]   left_entry_i,
  input  wire logic                                left_after_i,
  input  wire logic signed [sli_pkg::ValueW-1:0]   right_entry_i,
  input  wire logic                                found_i,
  output logic signed [sli_pkg::ValueW-1:0]        entry_o,
  output logic                                     after_o,
  output logic                                     match_o
);

  logic signed [sli_pkg::ValueW-1:0] entry_q;
  logic after_q;
  logic match_q;
  logic occupied;

  // a cell holds an entry when its place lies below the count
  assign occupied = count_i > CntW'(Idx);

  // compare flags: at or past the insert point, and equal to the key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_q <= 1'b0;
      match_q <= 1'b0;
    end else if (cmd_i.cmp_en) begin
      after_q <= !occupied || (entry_q >= key_i);
      match_q <= occupied && (entry_q == key_i);
    end
  end

  // entry update: shift toward the tail on insert, toward the head on delete
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_en && after_q) begin
      entry_q <= left_after_i ? left_entry_i : key_i;
    end else if (cmd_i.del_en && found_i && after_q) begin
      entry_q <= right_entry_i;
    end
  end

  assign entry_o = entry_q;
  assign after_o = after_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

/* sv/sorted_list_insert_delete_top.sv */
// Sorted list insert/delete, top level: chain of compare-and-shift cells.
// Sequence: accept, compare, shift, result load; m_axis_tvalid rises at the
// result load, which waits until the result register is free. One item at a time;
// a new item is taken while the previous result still waits in its register.
// Reset: entry count and control cleared; cell entries are not reset.
// Depends on sli_pkg and sli_cell.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_insert_delete_top #(
  parameter int unsigned CAPACITY = sli_pkg::CapacityDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // s_axis_tdata: op [0], value [32:1], zero fill [39:33]
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [sli_pkg::InDataW-1:0]     s_axis_tdata,
  // m_axis_tdata: status [1:0], entry_count [8:2], smallest_value [40:9],
  // smallest_valid [41], zero fill [47:42]
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [sli_pkg::OutDataW-1:0]         m_axis_tdata
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD,
    S_RESP
  } state_e;

  state_e state_q;
  logic op_q;
  logic signed [sli_pkg::ValueW-1:0] key_q;
  logic [CntW-1:0] count_q;
  logic [sli_pkg::StatusW-1:0] status_q;
  logic m_valid_q;
  logic [sli_pkg::OutDataW-1:0] m_data_q;

  sli_pkg::cell_cmd_t cmd;
  logic signed [sli_pkg::ValueW-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0] after;
  logic [CAPACITY-1:0] match;
  logic found;
  logic full;
  logic in_xfer;
  logic out_free;
  logic [CntW+sli_pkg::CountW-1:0] count_ext;
  logic signed [sli_pkg::ValueW-1:0] smallest;

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign found = |match;
  assign full = count_q == CntW'(CAPACITY);
  assign count_ext = {{sli_pkg::CountW{1'b0}}, count_q};
  assign smallest = (count_q != '0) ? entry[0] : '0;

  // command to the cells for the current step
  always_comb begin
    cmd.cmp_en = state_q == S_CMP;
    cmd.ins_en = (state_q == S_UPD) && (op_q == sli_pkg::OpInsert) && !full;
    cmd.del_en = (state_q == S_UPD) && (op_q == sli_pkg::OpDelete);
  end

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [sli_pkg::ValueW-1:0] left_entry;
    logic left_after;
    logic signed [sli_pkg::ValueW-1:0] right_entry;
    if (i == 0) begin : g_head
      assign left_entry = key_q;
      assign left_after = 1'b0;
    end else begin : g_mid
      assign left_entry = entry[i-1];
      assign left_after = after[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = entry[i];
    end else begin : g_body
      assign right_entry = entry[i+1];
    end
    sli_cell #(
      .Idx (i),
      .CntW(CntW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .key_i        (key_q),
      .count_i      (count_q),
      .left_entry_i (left_entry),
      .left_after_i (left_after),
      .right_entry_i(right_entry),
      .found_i      (found),
      .entry_o      (entry[i]),
      .after_o      (after[i]),
      .match_o      (match[i])
    );
  end

  // sequencer, count, status and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      status_q <= sli_pkg::StInserted;
      op_q <= sli_pkg::OpInsert;
      key_q <= '0;
      m_valid_q <= 1'b0;
      m_data_q <= '0;
    end else begin
      // result taken; the result load below refills it in the same cycle
      if (m_valid_q && m_axis_tready && (state_q != S_RESP)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            op_q <= s_axis_tdata[0];
            key_q <= s_axis_tdata[sli_pkg::ValueW:1];
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          state_q <= S_UPD;
        end
        S_UPD: begin
          if (op_q == sli_pkg::OpInsert) begin
            if (full) begin
              status_q <= sli_pkg::StFull;
            end else begin
              status_q <= sli_pkg::StInserted;
              count_q <= count_q + 1'b1;
            end
          end else begin
            if (found) begin
              status_q <= sli_pkg::StDeleted;
              count_q <= count_q - 1'b1;
            end else begin
              status_q <= sli_pkg::StNotFound;
            end
          end
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q <= {
              {(sli_pkg::OutDataW - sli_pkg::OutValidBit - 1){1'b0}},
              count_q != '0,
              smallest,
              count_ext[sli_pkg::CountW-1:0],
              status_q
            };
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata = m_data_q;

endmodule

`default_nettype wire

/* sv/sli_port_checker.sv */
// sorted list insert/delete: assertions on the top-level ports over time
// depends on sli_pkg; bound to sorted_list_insert_delete_top below
`timescale 1ns / 1ps
`default_nettype none

module sli_port_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tvalid,
  input wire logic                         s_axis_tready,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [sli_pkg::OutDataW-1:0] m_axis_tdata
);

  logic [sli_pkg::StatusW-1:0] st;
  logic [sli_pkg::CountW-1:0] cnt;
  logic vld;

  assign st = m_axis_tdata[sli_pkg::OutStatusLsb +: sli_pkg::StatusW];
  assign cnt = m_axis_tdata[sli_pkg::OutCountLsb +: sli_pkg::CountW];
  assign vld = m_axis_tdata[sli_pkg::OutValidBit];

  // one item in flight: no transfer right after an accepted one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // smallest valid flag agrees with the count
  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((cnt == '0) == !vld))
    else $error("smallest_valid disagrees with entry_count");

  // a successful insert leaves at least one entry
  a_insert_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st == sli_pkg::StInserted) |-> vld && (cnt != '0))
    else $error("insert reported with an empty table");

endmodule

bind sorted_list_insert_delete_top sli_port_checker u_sli_port_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
